/* src/vm86_sensitive_instruction_emulator_unit_defines.svh */
// Assertion macros for the vm86 sensitive instruction emulator.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef VM86_SENSITIVE_INSTRUCTION_EMULATOR_UNIT_DEFINES_SVH
`define VM86_SENSITIVE_INSTRUCTION_EMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define VSIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vsie: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define VSIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vsie: next-cycle check failed");

`endif

/* src/vsie_pkg.sv */
// Package for the vm86 sensitive instruction emulator: opcodes, codes,
// request and result structures. No dependencies.
`timescale 1ns / 1ps

package vsie_pkg;

  // Trapped opcodes
  localparam logic [7:0] OP_PUSHF = 8'h9C;
  localparam logic [7:0] OP_POPF  = 8'h9D;
  localparam logic [7:0] OP_INT   = 8'hCD;
  localparam logic [7:0] OP_IRET  = 8'hCF;
  localparam logic [7:0] OP_CLI   = 8'hFA;
  localparam logic [7:0] OP_STI   = 8'hFB;
  localparam logic [7:0] OP_OUTB  = 8'hEE;
  localparam logic [7:0] OP_OUTW  = 8'hEF;
  localparam logic [7:0] OP_INB   = 8'hEC;
  localparam logic [7:0] OP_INW   = 8'hED;

  // eflags bits forced on every pop, and the interrupt flag position
  localparam logic [31:0] FLAGS_POP_SET = 32'h0002_0200;
  localparam int unsigned FLAG_IF_BIT   = 9;
  localparam logic [31:0] MASK_RESET    = 32'h0000_0DD5;
  localparam logic [7:0]  NEST_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_FINISHED  = 2'd1,
    ST_UNHANDLED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PORT_NONE  = 3'd0,
    PORT_OUT_B = 3'd1,
    PORT_OUT_W = 3'd2,
    PORT_IN_B  = 3'd3,
    PORT_IN_W  = 3'd4
  } port_op_t;

  // One trapped instruction
  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  vector_byte;
    logic [3:0]  prefix_count;
    logic        operand_wide;
    logic [31:0] code_pointer;
    logic [15:0] stack_pointer;
    logic [31:0] flags_in;
    logic [31:0] accumulator;
    logic [15:0] port_register;
    logic [47:0] stack_top;
    logic [31:0] vector_entry;
    logic [15:0] port_read_data;
  } req_t;

  // One emulation result
  typedef struct packed {
    status_t     status;
    logic [31:0] new_code_pointer;
    logic [15:0] new_stack_pointer;
    logic [31:0] new_flags;
    logic [31:0] new_accumulator;
    logic [47:0] push_data;
    logic [1:0]  push_words;
    port_op_t    port_operation;
    logic [15:0] port_address;
    logic [15:0] port_write_data;
  } rsp_t;

  // Monitor state carried between instructions
  typedef struct packed {
    logic       vif;
    logic [7:0] nest;
  } ctx_t;

endpackage

/* src/vsie_in_reg.sv */
// Input request register of the emulator.
// Depends on vsie_pkg (req_t).
`timescale 1ns / 1ps

module vsie_in_reg
  import vsie_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  input  logic advance,
  output logic req_valid,
  output req_t req
);

  logic valid_r, valid_nxt;
  req_t req_r;

  // Free when empty or when the held request moves on this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

/* src/vsie_exec.sv */
// Single-pass emulation of one trapped instruction (combinational).
// Depends on vsie_pkg (req_t, rsp_t, ctx_t, opcodes).
`timescale 1ns / 1ps

module vsie_exec
  import vsie_pkg::*;
(
  input  req_t        req,
  input  ctx_t        ctx,
  input  logic [31:0] flags_mask,
  output rsp_t        rsp,
  output ctx_t        ctx_nxt
);

  logic [15:0] ip_adj;
  logic [15:0] ip_inc;
  logic [15:0] cs_cur;
  logic [15:0] w0, w1, w2;
  logic [31:0] fl_masked;
  logic [31:0] pop_wide;
  logic [15:0] fl_low_vif;

  // Common operands
  always_comb begin
    ip_adj     = req.code_pointer[15:0] + {12'd0, req.prefix_count};
    ip_inc     = ip_adj + 16'd1;
    cs_cur     = req.code_pointer[31:16];
    w0         = req.stack_top[15:0];
    w1         = req.stack_top[31:16];
    w2         = req.stack_top[47:32];
    fl_masked  = req.flags_in & flags_mask;
    pop_wide   = {w1, w0};
    fl_low_vif = {req.flags_in[15:10], ctx.vif, req.flags_in[8:0]};
  end

  // Instruction decode and update
  always_comb begin
    rsp.status            = ST_SUCCESS;
    rsp.new_code_pointer  = {cs_cur, ip_inc};
    rsp.new_stack_pointer = req.stack_pointer;
    rsp.new_flags         = req.flags_in;
    rsp.new_accumulator   = req.accumulator;
    rsp.push_data         = 48'd0;
    rsp.push_words        = 2'd0;
    rsp.port_operation    = PORT_NONE;
    rsp.port_address      = 16'd0;
    rsp.port_write_data   = 16'd0;
    ctx_nxt               = ctx;

    case (req.opcode)
      OP_PUSHF: begin
        if (req.operand_wide) begin
          rsp.new_stack_pointer = req.stack_pointer - 16'd4;
          rsp.push_data  = {16'd0, fl_masked[31:10], ctx.vif, fl_masked[8:0]};
          rsp.push_words = 2'd2;
        end else begin
          rsp.new_stack_pointer = req.stack_pointer - 16'd2;
          rsp.push_data  = {32'd0, fl_low_vif};
          rsp.push_words = 2'd1;
        end
      end
      OP_POPF: begin
        if (req.operand_wide) begin
          rsp.new_flags         = FLAGS_POP_SET | (pop_wide & flags_mask);
          ctx_nxt.vif           = pop_wide[FLAG_IF_BIT];
          rsp.new_stack_pointer = req.stack_pointer + 16'd4;
        end else begin
          rsp.new_flags         = FLAGS_POP_SET | {16'd0, w0};
          ctx_nxt.vif           = w0[FLAG_IF_BIT];
          rsp.new_stack_pointer = req.stack_pointer + 16'd2;
        end
      end
      OP_INT: begin
        // Push return ip past the two-byte instruction, cs, flags
        rsp.new_stack_pointer = req.stack_pointer - 16'd6;
        rsp.push_data         = {fl_low_vif, cs_cur, ip_adj + 16'd2};
        rsp.push_words        = 2'd3;
        rsp.new_code_pointer  = req.vector_entry;
        if (ctx.nest != NEST_MAX) begin
          ctx_nxt.nest = ctx.nest + 8'd1;
        end
      end
      OP_IRET: begin
        rsp.new_code_pointer  = {w1, w0};
        rsp.new_flags         = FLAGS_POP_SET | {16'd0, w2};
        ctx_nxt.vif           = w2[FLAG_IF_BIT];
        rsp.new_stack_pointer = req.stack_pointer + 16'd6;
        // Outermost return ends the monitor session
        if (ctx.nest == 8'd0) begin
          rsp.status = ST_FINISHED;
        end else begin
          ctx_nxt.nest = ctx.nest - 8'd1;
        end
      end
      OP_CLI: begin
        ctx_nxt.vif = 1'b0;
      end
      OP_STI: begin
        ctx_nxt.vif = 1'b1;
      end
      OP_OUTB: begin
        rsp.port_operation  = PORT_OUT_B;
        rsp.port_address    = req.port_register;
        rsp.port_write_data = {8'd0, req.accumulator[7:0]};
      end
      OP_OUTW: begin
        rsp.port_operation  = PORT_OUT_W;
        rsp.port_address    = req.port_register;
        rsp.port_write_data = req.accumulator[15:0];
      end
      OP_INB: begin
        rsp.port_operation  = PORT_IN_B;
        rsp.port_address    = req.port_register;
        rsp.new_accumulator = {req.accumulator[31:8], req.port_read_data[7:0]};
      end
      OP_INW: begin
        rsp.port_operation  = PORT_IN_W;
        rsp.port_address    = req.port_register;
        rsp.new_accumulator = {req.accumulator[31:16], req.port_read_data};
      end
      default: begin
        // Not emulated: step past the prefixes only
        rsp.status           = ST_UNHANDLED;
        rsp.new_code_pointer = {cs_cur, ip_adj};
      end
    endcase
  end

endmodule

/* src/vsie_ctx.sv */
// Monitor state: virtual interrupt flag, nesting level and flags mask.
// Depends on vsie_pkg (ctx_t, MASK_RESET).
`timescale 1ns / 1ps

module vsie_ctx
  import vsie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        advance,
  input  ctx_t        ctx_nxt,
  output ctx_t        ctx,
  output logic [31:0] flags_mask
);

  ctx_t        ctx_r;
  logic [31:0] mask_r, mask_nxt;

  assign mask_nxt = cfg_we ? cfg_data : mask_r;

  // Virtual flag and nesting level move with each executed request; the mask loads on a configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r  <= '0;
      mask_r <= MASK_RESET;
    end else begin
      mask_r <= mask_nxt;
      if (advance) begin
        ctx_r <= ctx_nxt;
      end
    end
  end

  assign ctx        = ctx_r;
  assign flags_mask = mask_r;

endmodule

/* src/vsie_out_reg.sv */
// Result register of the emulator, loaded when a request executes.
// Depends on vsie_pkg (rsp_t).
`timescale 1ns / 1ps

module vsie_out_reg
  import vsie_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  rsp_t rsp,
  output logic can_take,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);

  logic valid_r, valid_nxt;
  rsp_t rsp_r;

  // Room when empty or being drained this cycle
  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

/* src/vm86_sensitive_instruction_emulator_unit.sv */
// Virtual 8086 mode monitor: emulates one trapped sensitive instruction
// per request (PUSHF, POPF, INT, IRET, CLI, STI, byte/word IN and OUT).
//
// Channels: in_* carries one trapped instruction with the guest registers
// it needs; out_* returns one result per request (status, new cs:ip, sp,
// eflags, eax, stack words to store and the port access). cfg_* writes the
// eflags pass mask used by 32-bit PUSHF/POPF; cfg_ready is always high.
// Path: a request passes through the input register, then single-pass
// decode/update into the result register, which drives out_valid.
// Throughput: one request per cycle while the result channel is not stalled;
// the nesting level and virtual flag are updated as each request
// leaves the input register, so back-to-back requests see each other.
// Reset: both stages empty, virtual flag clear, nesting level 0, mask
// 0xDD5. When the receiver stalls the result is held in the result
// register; one more request can wait in the input register, after which
// in_ready drops until out_ready returns.
// Depends on vsie_pkg, vsie_in_reg, vsie_exec, vsie_ctx, vsie_out_reg and
// the assertion macro header.
`timescale 1ns / 1ps
`include "vm86_sensitive_instruction_emulator_unit_defines.svh"

module vm86_sensitive_instruction_emulator_unit
  import vsie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // Request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_vector_byte,
  input  logic [3:0]  in_prefix_count,
  input  logic        in_operand_wide,
  input  logic [31:0] in_code_pointer,
  input  logic [15:0] in_stack_pointer,
  input  logic [31:0] in_flags_in,
  input  logic [31:0] in_accumulator,
  input  logic [15:0] in_port_register,
  input  logic [47:0] in_stack_top,
  input  logic [31:0] in_vector_entry,
  input  logic [15:0] in_port_read_data,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_new_code_pointer,
  output logic [15:0] out_new_stack_pointer,
  output logic [31:0] out_new_flags,
  output logic [31:0] out_new_accumulator,
  output logic [47:0] out_push_data,
  output logic [1:0]  out_push_words,
  output logic [2:0]  out_port_operation,
  output logic [15:0] out_port_address,
  output logic [15:0] out_port_write_data
);

  req_t        in_req;
  req_t        req;
  logic        req_valid;
  rsp_t        rsp;
  rsp_t        out_rsp;
  ctx_t        ctx;
  ctx_t        ctx_nxt;
  logic [31:0] flags_mask;
  logic        out_can_take;
  logic        advance;

  assign cfg_ready = 1'b1;

  // Gather request fields
  assign in_req = '{
    opcode:         in_opcode,
    vector_byte:    in_vector_byte,
    prefix_count:   in_prefix_count,
    operand_wide:   in_operand_wide,
    code_pointer:   in_code_pointer,
    stack_pointer:  in_stack_pointer,
    flags_in:       in_flags_in,
    accumulator:    in_accumulator,
    port_register:  in_port_register,
    stack_top:      in_stack_top,
    vector_entry:   in_vector_entry,
    port_read_data: in_port_read_data
  };

  // Held request executes when the result register has room
  assign advance = req_valid && out_can_take;

  vsie_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  vsie_exec u_exec (
    .req        (req),
    .ctx        (ctx),
    .flags_mask (flags_mask),
    .rsp        (rsp),
    .ctx_nxt    (ctx_nxt)
  );

  vsie_ctx u_ctx (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .advance    (advance),
    .ctx_nxt    (ctx_nxt),
    .ctx        (ctx),
    .flags_mask (flags_mask)
  );

  vsie_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .rsp       (rsp),
    .can_take  (out_can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  // Result fields
  assign out_status            = out_rsp.status;
  assign out_new_code_pointer  = out_rsp.new_code_pointer;
  assign out_new_stack_pointer = out_rsp.new_stack_pointer;
  assign out_new_flags         = out_rsp.new_flags;
  assign out_new_accumulator   = out_rsp.new_accumulator;
  assign out_push_data         = out_rsp.push_data;
  assign out_push_words        = out_rsp.push_words;
  assign out_port_operation    = out_rsp.port_operation;
  assign out_port_address      = out_rsp.port_address;
  assign out_port_write_data   = out_rsp.port_write_data;

  // Checks
  `VSIE_ASSERT_NOW(a_stall_only_when_full, !in_ready, req_valid && out_valid && !out_ready)
  `VSIE_ASSERT_NEXT(a_nest_saturates, advance && req.opcode == OP_INT && ctx.nest == NEST_MAX, ctx.nest == NEST_MAX)
  `VSIE_ASSERT_NEXT(a_unhandled_keeps_state, advance && rsp.status == ST_UNHANDLED, ctx == $past(ctx))
  `VSIE_ASSERT_NOW(a_finish_is_plain, out_valid && out_rsp.status == ST_FINISHED, out_rsp.push_words == 2'd0 && out_rsp.port_operation == PORT_NONE)

endmodule
